// ----- rtl/sle_pkg.sv -----
// ============================================================================
// sle_pkg: shared types and constants of the serial line editor
// Holds the line geometry, the configuration register indexes, the state
// machine encoding and the command and status groups between the controller
// and the datapath.
// ============================================================================
package sle_pkg;

	// Receive buffer size; one slot is kept for the terminator and one spare.
	localparam int BufferSize = 32;
	localparam int LineCap    = BufferSize - 2;
	localparam int IdxW       = (LineCap > 1) ? $clog2(LineCap) : 1;
	localparam int FillW      = $clog2(LineCap + 1);
	localparam int ByteW      = 8;
	localparam int CfgIdxW    = 2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_ENTER = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_ERASE = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_BLANK = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [ByteW-1:0] ENTER_RST = 8'd13;
	localparam logic [ByteW-1:0] ERASE_RST = 8'd8;
	localparam logic [ByteW-1:0] BLANK_RST = 8'd32;

	// Output beat kinds.
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_ECHO,
		ST_ERASE1,
		ST_ERASE2,
		ST_ERASE3,
		ST_DRAIN
	} sle_state_t;

	// Source of the byte loaded into the output register.
	typedef enum logic [1:0] {
		SRC_RX,
		SRC_BLANK,
		SRC_LINE
	} sle_src_t;

	typedef struct packed {
		logic     capture;   // latch the received byte
		logic     store;     // write the byte into the line and grow the line
		logic     fill_dec;  // drop the last character
		logic     fill_clr;  // empty the line
		logic     rd_start;  // read the first line character
		logic     rd_next;   // read the following line character
		logic     out_load;  // load the output register
		sle_src_t src;
		logic     out_kind;
		logic     out_last;
	} sle_cmd_t;

	typedef struct packed {
		logic is_enter;
		logic is_erase;
		logic line_empty;
		logic line_full;
		logic line_end;   // the character in the read register is the last one
		logic out_free;   // the output register can take a beat this cycle
	} sle_sts_t;

endpackage

// ----- rtl/sle_ram.sv -----
// ============================================================================
// sle_ram: generic single-port-write RAM
// One write port and one read port with a registered read; the read data
// holds while no read is issued.
// ============================================================================
module sle_ram #(
	parameter int Width = 8,
	parameter int Depth = 30
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                            rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/sle_datapath.sv -----
// ============================================================================
// sle_datapath: registers, line memory and output register of the editor
// Keeps the configuration codes, the received byte, the fill count, the
// drain pointer and the output beat, and carries out controller commands.
// ============================================================================
module sle_datapath
	import sle_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0]   cfg_data,
	input  logic [ByteW-1:0]   rx_byte,
	input  sle_cmd_t           cmd,
	output sle_sts_t           sts,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ByteW-1:0]   m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);

	logic [ByteW-1:0] enter_q;
	logic [ByteW-1:0] erase_q;
	logic [ByteW-1:0] blank_q;
	logic [ByteW-1:0] rx_q;
	logic [FillW-1:0] fill_q;
	logic [IdxW-1:0]  rd_idx_q;
	logic             out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic             out_kind_q;
	logic             out_last_q;

	logic [IdxW-1:0]  raddr;
	logic [ByteW-1:0] rdata;
	logic [ByteW-1:0] out_byte_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q <= ENTER_RST;
			erase_q <= ERASE_RST;
			blank_q <= BLANK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENTER: enter_q <= cfg_data;
				CFG_ERASE: erase_q <= cfg_data;
				CFG_BLANK: blank_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rx_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_clr) begin
			fill_q <= '0;
		end else if (cmd.store) begin
			fill_q <= fill_q + FillW'(1);
		end else if (cmd.fill_dec) begin
			fill_q <= fill_q - FillW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_start) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_next) begin
			rd_idx_q <= rd_idx_q + IdxW'(1);
		end
	end

	// The next read looks one character ahead of the one being delivered.
	assign raddr = cmd.rd_start ? '0 : rd_idx_q + IdxW'(1);

	sle_ram #(
		.Width(ByteW),
		.Depth(LineCap)
	) u_line_ram (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(fill_q[IdxW-1:0]),
		.wdata(rx_q),
		.re   (cmd.rd_start | cmd.rd_next),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		unique case (cmd.src)
			SRC_RX:    out_byte_d = rx_q;
			SRC_BLANK: out_byte_d = blank_q;
			SRC_LINE:  out_byte_d = rdata;
			default:   out_byte_d = rx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte_q <= out_byte_d;
			out_kind_q <= cmd.out_kind;
			out_last_q <= cmd.out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	assign sts.is_enter   = (rx_q == enter_q);
	assign sts.is_erase   = (rx_q == erase_q);
	assign sts.line_empty = (fill_q == '0);
	assign sts.line_full  = (fill_q == FillW'(LineCap));
	assign sts.line_end   = ((FillW'(rd_idx_q) + FillW'(1)) == fill_q);
	assign sts.out_free   = !out_valid_q || m_tready;

`ifndef ASSERT_OFF
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(LineCap))
		else $error("fill count beyond line capacity");

	a_store_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !sts.line_full)
		else $error("store into a full line");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output beat overwritten before it was taken");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_next |-> !sts.line_end && !sts.line_empty)
		else $error("line read past its last character");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_clr |=> sts.line_empty)
		else $error("line not empty after clear");
`endif

endmodule

// ----- rtl/sle_ctrl.sv -----
// ============================================================================
// sle_ctrl: controller of the serial line editor
// Accepts one received byte at a time, classifies it and sequences the echo
// beats or the drain of the stored line.
// ============================================================================
module sle_ctrl
	import sle_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  sle_sts_t sts,
	output sle_cmd_t cmd
);

	sle_state_t state_q;
	sle_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				// Enter wins when the enter and erase codes are equal.
				priority if (sts.is_enter) begin
					if (!sts.line_empty) begin
						cmd.rd_start = 1'b1;
						state_d      = ST_DRAIN;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (sts.is_erase) begin
					if (!sts.line_empty) begin
						cmd.fill_dec = 1'b1;
						state_d      = ST_ERASE1;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					if (!sts.line_full) begin
						cmd.store = 1'b1;
						state_d   = ST_ECHO;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ECHO: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.src      = SRC_RX;
					cmd.out_kind = KIND_ECHO;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_ERASE1: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.src      = SRC_RX;
					cmd.out_kind = KIND_ECHO;
					state_d      = ST_ERASE2;
				end
			end
			ST_ERASE2: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.src      = SRC_BLANK;
					cmd.out_kind = KIND_ECHO;
					state_d      = ST_ERASE3;
				end
			end
			ST_ERASE3: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.src      = SRC_RX;
					cmd.out_kind = KIND_ECHO;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.src      = SRC_LINE;
					cmd.out_kind = KIND_LINE;
					cmd.out_last = sts.line_end;
					if (sts.line_end) begin
						cmd.fill_clr = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/serial_line_editor_with_echo.sv -----
// ============================================================================
// serial_line_editor_with_echo: command line editor with local echo
// Assembles received terminal bytes into a line, echoes them, handles erase
// and releases the finished line on enter.
// ============================================================================
// Each received byte is taken in one beat and handled on its own: the input
// accepts the next byte only once the previous one has been fully worked off.
// A byte is first accepted and then classified; a normal byte then yields
// its echo beat, an erase yields three echo beats (erase, blank, erase) one
// per cycle, and an enter streams the stored line out of the line memory at
// one character per cycle, in both cases while the output is not stalled.
// A full line holds 30 characters. The line memory has a registered read,
// which is why the drain reads one character ahead. A finished beat waits
// in the output register, and the block keeps accepting input while it
// waits. Line beats carry tuser high and echo beats carry it low; tlast
// marks the final beat that one received byte causes. Bytes arriving on a
// full line are dropped, and enter or erase on an empty line produce
// nothing. The configuration port is meant to be written only while the
// block is idle.
// ============================================================================
module serial_line_editor_with_echo
	import sle_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port: index 0 enter code, 1 erase code, 2 blank code.
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0]   cfg_data,
	// Received byte stream.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [ByteW-1:0]   s_tdata,   // [7:0] rx_data
	// Echo and line stream.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ByteW-1:0]   m_tdata,   // [7:0] out_byte
	output logic               m_tuser,   // [0] kind: 0 echo, 1 line character
	output logic               m_tlast    // final beat caused by one received byte
);

	sle_cmd_t cmd;
	sle_sts_t sts;

	// The controller sequences the work for each received byte.
	sle_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// The datapath holds the codes, the line memory and the output register.
	sle_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rx_byte  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- verif/serial_line_editor_with_echo_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// serial_line_editor_with_echo_test: self-checking bench of the line editor
// Feeds received bytes through the input stream and tracks every output beat
// against a behavioral model of the editor kept inside the bench. A short
// scripted run covers the empty line, the full line and the byte extremes.
// Randomized command lines follow under several code settings, with random
// stalls on both streams and one long output hold-off.
// ============================================================================
module serial_line_editor_with_echo_test;
	import sle_pkg::*;

	// Index with no register behind it; a write there must change nothing.
	localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

	localparam int CycleLimit  = 400000;
	localparam int SettleCycles = 40;
	localparam int DrainCycles  = 40;
	localparam int IdlePercent  = 29;
	localparam int HoldAt       = 200;  // input beats taken before the hold-off
	localparam int HoldCycles   = 400;
	localparam int CalmFrom     = 350;  // window of input beats with no idling
	localparam int CalmTo       = 450;
	localparam int PhaseItems   = 85;

	// How a scripted byte is checked: by the model, or against a value typed
	// into the script (a single echo of the byte, or nothing at all).
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_ECHO,
		CHK_SILENT
	} row_check_t;

	typedef struct {
		logic [ByteW-1:0] rx;
		int               reps;   // the byte is sent reps times, counting up
		row_check_t       how;
	} stim_row_t;

	typedef struct {
		logic             kind;
		logic [ByteW-1:0] data;
		logic             last;
	} beat_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [ByteW-1:0]   cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [ByteW-1:0]   s_tdata;    // [7:0] rx_data
	logic               m_tvalid;
	logic               m_tready;
	logic [ByteW-1:0]   m_tdata;    // [7:0] out_byte
	logic               m_tuser;    // [0] kind
	logic               m_tlast;

	serial_line_editor_with_echo i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Model state: the code registers as the bench last wrote them and the
	// line as it has been typed so far.
	logic [ByteW-1:0] enter_code;
	logic [ByteW-1:0] erase_code;
	logic [ByteW-1:0] blank_code;
	logic [ByteW-1:0] line_mem [LineCap];
	int               line_len;

	beat_t      pending_beats [$];   // beats owed by the block, oldest first
	row_check_t check_kinds [$];     // how each offered byte is to be checked
	int         mismatches;
	int         bytes_taken;         // input beats accepted so far
	int         useful_items;        // accepted bytes that caused any beat
	int         beats_seen;
	int         cycles;

	// Scripted run, starting from the reset codes (enter 13, erase 8, blank 32).
	// The first two rows hit an empty line, the fill row brings the line to
	// exactly its capacity, and the rows after it probe the full line.
	stim_row_t script [0:16] = '{
		'{ENTER_RST, 1, CHK_SILENT},        // enter on an empty line
		'{ERASE_RST, 1, CHK_SILENT},        // erase on an empty line
		'{8'h00, 1, CHK_ECHO},
		'{8'hFF, 1, CHK_ECHO},
		'{8'h55, 1, CHK_ECHO},
		'{8'hAA, 1, CHK_ECHO},
		'{ERASE_RST, 1, CHK_PREDICT},
		'{ENTER_RST, 1, CHK_PREDICT},
		'{8'h41, LineCap, CHK_PREDICT},     // fill the line to the brim
		'{8'h7E, 1, CHK_SILENT},            // dropped: no room left
		'{ERASE_RST, 1, CHK_PREDICT},       // erase works on a full line
		'{8'h30, 1, CHK_ECHO},              // refills the last slot
		'{8'h31, 1, CHK_SILENT},            // dropped again
		'{ENTER_RST, 1, CHK_PREDICT},       // releases all thirty characters
		'{8'h80, 1, CHK_ECHO},
		'{8'h7F, 1, CHK_ECHO},
		'{ENTER_RST, 1, CHK_PREDICT}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit calm_now();
		return bytes_taken >= CalmFrom && bytes_taken < CalmTo;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	// Works out the beats that one received byte causes and updates the line.
	// Enter wins when the enter and erase codes are set equal.
	task automatic edit_line(input logic [ByteW-1:0] rx, input row_check_t how);
		beat_t owed [$];
		owed = {};
		if (rx == enter_code) begin
			for (int i = 0; i < line_len; i++)
				owed.push_back('{KIND_LINE, line_mem[i], i == line_len - 1});
			line_len = 0;
		end else if (rx == erase_code) begin
			if (line_len != 0) begin
				line_len--;
				owed.push_back('{KIND_ECHO, erase_code, 1'b0});
				owed.push_back('{KIND_ECHO, blank_code, 1'b0});
				owed.push_back('{KIND_ECHO, erase_code, 1'b1});
			end
		end else if (line_len < LineCap) begin
			line_mem[line_len] = rx;
			line_len++;
			owed.push_back('{KIND_ECHO, rx, 1'b1});
		end
		if (owed.size() != 0)
			useful_items++;
		// Scripted rows with a typed answer replace what the model says.
		if (how == CHK_ECHO) begin
			owed = {};
			owed.push_back('{KIND_ECHO, rx, 1'b1});
		end else if (how == CHK_SILENT) begin
			owed = {};
		end
		foreach (owed[i])
			pending_beats.push_back(owed[i]);
	endtask

	task automatic check_beat();
		beat_t want;
		if (pending_beats.size() == 0) begin
			report_mismatch($sformatf("beat %0d (data %02h) with none owed", beats_seen,
				m_tdata));
		end else begin
			want = pending_beats.pop_front();
			if (m_tuser !== want.kind)
				report_mismatch($sformatf("beat %0d kind %b, expected %b", beats_seen,
					m_tuser, want.kind));
			if (m_tdata !== want.data)
				report_mismatch($sformatf("beat %0d data %02h, expected %02h", beats_seen,
					m_tdata, want.data));
			if (m_tlast !== want.last)
				report_mismatch($sformatf("beat %0d last %b, expected %b", beats_seen,
					m_tlast, want.last));
		end
		beats_seen++;
	endtask

	// Everything is sampled here at the rising edge. Output beats are checked
	// before the input beat of the same edge is modeled; a byte cannot cause a
	// beat on the very edge at which it is accepted.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
		if (m_tvalid === 1'b1 && m_tready === 1'b1)
			check_beat();
		if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
			edit_line(s_tdata, check_kinds.pop_front());
			bytes_taken++;
		end
	end

	// Receiver side. It stalls at random except in the calm window, and once,
	// after enough input has gone in, holds off long enough for the block to
	// back up and stop taking bytes while the sender keeps offering.
	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && bytes_taken >= HoldAt) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			m_tready <= calm_now() || ($urandom_range(0, 99) >= IdlePercent);
		end
	end

	// Offers one byte and returns at the falling edge after it was taken.
	// The valid is only dropped while the sender idles, so back-to-back bytes keep
	// it high without a glitch.
	task automatic send_byte(input logic [ByteW-1:0] rx, input row_check_t how);
		while (!calm_now() && $urandom_range(0, 99) < IdlePercent) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		check_kinds.push_back(how);
		s_tdata  <= rx;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_ENTER: enter_code = val;
			CFG_ERASE: erase_code = val;
			CFG_BLANK: blank_code = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Codes change only with the block at rest: every owed beat has left and
	// a byte that caused nothing has had time to be worked off.
	task automatic write_codes(input logic [ByteW-1:0] ent, input logic [ByteW-1:0] era,
			input logic [ByteW-1:0] blk, input bit poke_spare);
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		put_reg(CFG_ENTER, ent);
		put_reg(CFG_ERASE, era);
		put_reg(CFG_BLANK, blk);
		if (poke_spare)
			put_reg(CFG_SPARE, 8'h41);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ByteW-1:0] plain_byte();
		logic [ByteW-1:0] b;
		b = ByteW'($urandom_range(0, 255));
		while (b == enter_code || b == erase_code)
			b = ByteW'($urandom_range(0, 255));
		return b;
	endfunction

	// One typed command line: mostly short, now and then long enough to run
	// into the capacity. Some erases are mixed in, and a line now and then is
	// left without its enter so that it carries over into the next one.
	task automatic random_line();
		int len;
		len = ($urandom_range(0, 5) == 0) ? $urandom_range(LineCap - 4, LineCap + 4)
			: $urandom_range(1, 10);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 99) < 15)
				send_byte(erase_code, CHK_PREDICT);
			else
				send_byte(plain_byte(), CHK_PREDICT);
		end
		if ($urandom_range(0, 9) != 0)
			send_byte(enter_code, CHK_PREDICT);
	endtask

	// Mostly well-formed lines; the rest is raw noise of any byte value.
	task automatic run_phase(input int goal);
		while (useful_items < goal) begin
			if ($urandom_range(0, 99) < 12)
				send_byte(ByteW'($urandom_range(0, 255)), CHK_PREDICT);
			else
				random_line();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_ENTER;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		enter_code = ENTER_RST;
		erase_code = ERASE_RST;
		blank_code = BLANK_RST;
		line_len   = 0;
		mismatches = 0;
		bytes_taken  = 0;
		useful_items = 0;
		beats_seen   = 0;
		cycles       = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[r])
			for (int k = 0; k < script[r].reps; k++)
				send_byte(ByteW'(script[r].rx + k), script[r].how);

		// Extremes of the codes, plus a write to the unused index.
		write_codes(8'h00, 8'hFF, 8'h00, 1'b1);
		run_phase(useful_items + PhaseItems);
		write_codes(8'hFF, 8'h00, 8'hFF, 1'b0);
		run_phase(useful_items + PhaseItems);
		// Enter and erase share a code, so that byte always ends the line.
		write_codes(8'h0A, 8'h0A, 8'h5F, 1'b0);
		run_phase(useful_items + PhaseItems);
		write_codes(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
			ByteW'($urandom_range(0, 255)), 1'b0);
		run_phase(useful_items + PhaseItems);
		write_codes(8'd13, 8'd127, 8'd46, 1'b0);
		run_phase(useful_items + PhaseItems);

		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sle_datapath.sv
rtl/sle_ctrl.sv
rtl/serial_line_editor_with_echo.sv
verif/serial_line_editor_with_echo_test.sv
